FILE: src/mia_pkg.sv
// Package for the MMIX integer unit: op codes, widths and helper types.
`timescale 1ns / 1ps
package mia_pkg;
	localparam int WordBits = 64;
	localparam int DivSteps = 4;

	typedef enum logic [4:0] {
		OP_ADD = 5'd0, OP_SUB = 5'd1, OP_ADDU = 5'd2, OP_SUBU = 5'd3,
		OP_ADDU2 = 5'd4, OP_ADDU4 = 5'd5, OP_ADDU8 = 5'd6, OP_ADDU16 = 5'd7,
		OP_MUL = 5'd8, OP_MULU = 5'd9, OP_DIV = 5'd10, OP_DIVU = 5'd11,
		OP_SL = 5'd12, OP_SLU = 5'd13, OP_SR = 5'd14, OP_SRU = 5'd15,
		OP_CMP = 5'd16, OP_CMPU = 5'd17
	} op_t;

	localparam logic [1:0] AUX_NONE = 2'd0;
	localparam logic [1:0] AUX_RH   = 2'd1;
	localparam logic [1:0] AUX_RR   = 2'd2;

	typedef logic [WordBits-1:0] word_t;

	typedef struct packed {
		word_t      result_word;
		word_t      aux_word;
		logic [1:0] aux_kind;
		logic       overflow_flag;
		logic       divide_check_flag;
	} res_t;
endpackage

FILE: src/mmix_integer_alu.sv
// Top level of the 64-bit MMIX integer unit.
`timescale 1ns / 1ps
// Usage:
//   Requests enter on the s_axis group; tdata packs op[4:0], operand_a,
//   operand_b and dividend_high from the low bit up. One result leaves on
//   m_axis per request: result_word, aux_word, aux_kind, overflow_flag,
//   divide_check_flag from the low bit up.
//   Every op goes through the same pipeline: an entry stage that prepares
//   operands and does adds, shifts and compares, sixteen divider stages of
//   four restoring steps each, a fix-up stage, and the output register.
//   The 64x64 product is built from four 32x32 partials in the entry stage
//   path and summed in later stages. Throughput is one request per cycle
//   while the output is not stalled.
//   The whole pipe advances together: when m_axis_tready is low and the
//   output holds a result, the pipe freezes, s_axis_tready drops, and
//   nothing is lost or repeated. Bubbles travel as cleared valid bits; an
//   empty output slot never blocks the pipe.
//   Reset clears all valid bits; the data registers are not reset.
module mmix_integer_alu (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [199:0] s_axis_tdata,  // op, operand_a, operand_b, dividend_high
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [135:0] m_axis_tdata   // result_word, aux_word, aux_kind, V, D
);
	import mia_pkg::*;
	localparam int Depth = WordBits / DivSteps + 2;

	logic [4:0] op;
	word_t a, b, rd;
	assign op = s_axis_tdata[4:0];
	assign a  = s_axis_tdata[68:5];
	assign b  = s_axis_tdata[132:69];
	assign rd = s_axis_tdata[196:133];

	// hold or advance the whole pipe; a stall only blocks if the tail is full
	logic [Depth-1:0] vld_q;
	logic adv;
	assign adv = !vld_q[Depth-1] || m_axis_tready;
	assign s_axis_tready = adv;

	// entry stage: simple ops finished here, divider and multiplier fed
	res_t  simple;
	logic  an, bn, big_sh;
	word_t ua, ub, sl_res, dnum_hi, dnum_lo, ddiv;
	logic  is_divu, div_ok;
	logic [WordBits:0] cmp_u;
	always_comb begin
		an = a[WordBits-1];
		bn = b[WordBits-1];
		big_sh = |b[WordBits-1:6];
		ua = an ? -a : a;
		ub = bn ? -b : b;
		sl_res = a << b[5:0];
		simple = '0;
		cmp_u = {1'b0, a} - {1'b0, b};
		unique case (op)
			OP_ADD: begin
				simple.result_word = a + b;
				simple.overflow_flag = (an == bn) && (simple.result_word[63] != an);
			end
			OP_SUB: begin
				simple.result_word = a - b;
				simple.overflow_flag = (an != bn) && (simple.result_word[63] != an);
			end
			OP_ADDU:   simple.result_word = a + b;
			OP_SUBU:   simple.result_word = a - b;
			OP_ADDU2:  simple.result_word = (a << 1) + b;
			OP_ADDU4:  simple.result_word = (a << 2) + b;
			OP_ADDU8:  simple.result_word = (a << 3) + b;
			OP_ADDU16: simple.result_word = (a << 4) + b;
			OP_SL: begin
				simple.result_word = big_sh ? '0 : sl_res;
				simple.overflow_flag = big_sh ? (a != '0)
					: (word_t'($signed(sl_res) >>> b[5:0]) != a);
			end
			OP_SLU: simple.result_word = big_sh ? '0 : sl_res;
			OP_SR:  simple.result_word = big_sh ? {WordBits{an}}
					: word_t'($signed(a) >>> b[5:0]);
			OP_SRU: simple.result_word = big_sh ? '0 : (a >> b[5:0]);
			OP_CMP: simple.result_word = (an != bn) ? (an ? '1 : word_t'(1))
					: (a == b ? '0 : (cmp_u[WordBits] ? '1 : word_t'(1)));
			OP_CMPU: simple.result_word = (a == b) ? '0
					: (cmp_u[WordBits] ? '1 : word_t'(1));
			default: simple = '0;
		endcase
		is_divu = (op == OP_DIVU);
		div_ok  = (b != '0) && (b > rd);
		dnum_hi = is_divu ? rd : '0;
		dnum_lo = is_divu ? a : ua;
		ddiv    = is_divu ? b : ub;
		if (ddiv == '0) ddiv = word_t'(1);
	end

	// side info that rides along with the divider
	typedef struct packed {
		logic [4:0] op;
		word_t a, b, rd, ub;
		logic an, bn, div_ok;
		res_t simple;
	} side_t;

	side_t side_q [Depth-2];
	side_t side_in;
	assign side_in = '{op: op, a: a, b: b, rd: rd, ub: ub, an: an, bn: bn,
		div_ok: div_ok, simple: simple};

	// multiplier: partial products registered, then summed over stages
	logic [63:0] pll_s1, plh_s1, phl_s1, phh_s1, phl_s2;
	logic [127:0] prod_s2;
	logic [127:0] prod_q [Depth-4];
	always_ff @(posedge clk) begin
		if (adv) begin
			pll_s1 <= a[31:0] * b[31:0];
			plh_s1 <= a[31:0] * b[63:32];
			phl_s1 <= a[63:32] * b[31:0];
			phh_s1 <= a[63:32] * b[63:32];
			prod_s2 <= {phh_s1, pll_s1} + {32'd0, plh_s1, 32'd0};
			phl_s2 <= phl_s1;
			// product pipe: hold the product until the divider tail
			prod_q[0] <= prod_s2 + {32'd0, phl_s2, 32'd0};
			for (int i = 1; i < Depth-4; i++)
				prod_q[i] <= prod_q[i-1];
		end
	end

	word_t quot, rem;
	mia_div u_div (.clk(clk), .adv(adv), .num_hi(dnum_hi),
		.num_lo(dnum_lo), .divisor(ddiv), .quot(quot), .rem(rem));

	always_ff @(posedge clk) if (adv) side_q[0] <= side_in;
	for (genvar i = 1; i < Depth-2; i++) begin : g_sq
		always_ff @(posedge clk) if (adv) side_q[i] <= side_q[i-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[Depth-2:0], s_axis_tvalid};
		end
	end

	// fix-up stage: signed division, products, select
	side_t sd;
	logic [127:0] pr;
	word_t hi_s, q, r;
	res_t fin;
	always_comb begin
		sd = side_q[Depth-3];
		pr = prod_q[Depth-5];
		fin = sd.simple;
		hi_s = pr[127:64] - (sd.an ? sd.b : '0) - (sd.bn ? sd.a : '0);
		q = quot;
		r = rem;
		case (sd.op)
			OP_MUL: begin
				fin.result_word = pr[63:0];
				fin.overflow_flag = hi_s != {WordBits{pr[63]}};
			end
			OP_MULU: begin
				fin.result_word = pr[63:0];
				fin.aux_word = pr[127:64];
				fin.aux_kind = AUX_RH;
			end
			OP_DIV: begin
				fin.aux_kind = AUX_RR;
				if (sd.b == '0) begin
					fin.result_word = '0;
					fin.aux_word = sd.a;
					fin.divide_check_flag = 1'b1;
				end else begin
					if (sd.an != sd.bn) begin
						q = -q;
						if (r != '0) begin
							q = q - word_t'(1);
							r = sd.ub - r;
						end
					end
					if (sd.bn) r = -r;
					fin.result_word = q;
					fin.aux_word = r;
					fin.overflow_flag = (sd.a == {1'b1, {(WordBits-1){1'b0}}})
						&& (sd.b == '1);
				end
			end
			OP_DIVU: begin
				fin.aux_kind = AUX_RR;
				fin.result_word = sd.div_ok ? quot : sd.rd;
				fin.aux_word = sd.div_ok ? rem : sd.a;
			end
			default: ;
		endcase
	end

	// output register pair: fix-up then out
	res_t fix_s1, out_q;
	always_ff @(posedge clk) begin
		if (adv) begin
			fix_s1 <= fin;
			out_q  <= fix_s1;
		end
	end

	assign m_axis_tvalid = vld_q[Depth-1];
	assign m_axis_tdata = {4'd0, out_q.divide_check_flag, out_q.overflow_flag,
		out_q.aux_kind, out_q.aux_word, out_q.result_word};

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while output stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("stalled result changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[129:128] != 2'd3)
		else $error("bad aux kind");
endmodule

FILE: src/mia_div.sv
// Pipelined restoring 128/64 divider: 64 one-bit steps over 16 stages of four steps.
`timescale 1ns / 1ps
module mia_div (
	input  logic             clk,
	input  logic             adv,
	input  mia_pkg::word_t   num_hi,
	input  mia_pkg::word_t   num_lo,
	input  mia_pkg::word_t   divisor,
	output mia_pkg::word_t   quot,
	output mia_pkg::word_t   rem
);
	import mia_pkg::*;
	localparam int Stages = WordBits / DivSteps;

	word_t r_q [1:Stages];
	word_t l_q [1:Stages];
	word_t d_q [1:Stages];
	word_t q_q [1:Stages];

	for (genvar s = 0; s < Stages; s++) begin : g_st
		word_t r_i, l_i, d_i, q_i;
		word_t r_n, l_n, q_n;
		if (s == 0) begin : g_first
			assign r_i = num_hi;
			assign l_i = num_lo;
			assign d_i = divisor;
			assign q_i = '0;
		end else begin : g_next
			assign r_i = r_q[s];
			assign l_i = l_q[s];
			assign d_i = d_q[s];
			assign q_i = q_q[s];
		end
		always_comb begin
			logic          carry;
			logic [WordBits:0] diff;
			r_n = r_i;
			l_n = l_i;
			q_n = q_i;
			for (int k = 0; k < DivSteps; k++) begin
				carry = r_n[WordBits-1];
				r_n   = {r_n[WordBits-2:0], l_n[WordBits-1]};
				l_n   = {l_n[WordBits-2:0], 1'b0};
				diff  = {1'b0, r_n} - {1'b0, d_i};
				q_n   = {q_n[WordBits-2:0], 1'b0};
				if (carry || !diff[WordBits]) begin
					r_n    = diff[WordBits-1:0];
					q_n[0] = 1'b1;
				end
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				r_q[s+1] <= r_n;
				l_q[s+1] <= l_n;
				d_q[s+1] <= d_i;
				q_q[s+1] <= q_n;
			end
		end
	end

	assign quot = q_q[Stages];
	assign rem  = r_q[Stages];
endmodule
